>>> rtl/tfp_pkg.sv
// Shared types, constants and helpers for the triangle formation points unit.
package tfp_pkg;

   localparam int ATAN_LEN = 30;

   // arctangent of 2^-i in 32 bit binary angle units, truncated
   localparam logic [31:0] ATAN_TABLE [ATAN_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
      32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
      32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
   };

   localparam logic signed [33:0] INV_GAIN_Q30  = 34'sd652032874;
   localparam logic signed [63:0] INV_SQRT3_Q30 = 64'sd619925131;
   localparam logic [15:0]        THIRD_TURN    = 16'd21845;

   typedef enum logic [2:0] {
      REG_BASE_X       = 3'd0,
      REG_BASE_Y       = 3'd1,
      REG_BASE_HEADING = 3'd2,
      REG_BASE_SCALE   = 3'd3,
      REG_SPACING      = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      VTX_ZERO  = 2'd0,
      VTX_PLUS  = 2'd1,
      VTX_MINUS = 2'd2
   } vertex_type;

   // values that ride alongside the angle through the rotator
   typedef struct packed {
      logic [1:0]          vtx;
      logic signed [31:0]  len;
      logic signed [31:0]  dsc;
      logic signed [32:0]  sx;
      logic signed [32:0]  sy;
   } side_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/tfp_front.sv
// Item holding, vertex issue and side length scaling stages.
module tfp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_offset_x,
   input  logic signed [31:0]  req_offset_y,
   input  logic signed [15:0]  req_offset_heading,
   input  logic signed [31:0]  req_offset_scale,
   input  logic signed [31:0]  base_x,
   input  logic signed [31:0]  base_y,
   input  logic [15:0]         base_heading,
   input  logic signed [31:0]  base_scale,
   input  logic signed [31:0]  spacing,
   output logic                out_valid,
   output logic [15:0]         out_ang,
   output tfp_pkg::side_type   out_side
);
   import tfp_pkg::*;

   logic               hold_v_ff, hold_v_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic signed [31:0] ox_ff, oy_ff, os_ff;
   logic [15:0]        h_ff;

   logic               a_v_ff;
   logic [1:0]         a_vtx_ff;
   logic [15:0]        a_ang_ff;
   logic signed [31:0] a_size_ff;
   logic signed [32:0] a_sx_ff, a_sy_ff;

   logic               b_v_ff;
   logic [1:0]         b_vtx_ff;
   logic [15:0]        b_ang_ff;
   logic signed [31:0] b_l_ff, b_d_ff;
   logic signed [32:0] b_sx_ff, b_sy_ff;

   logic               c_v_ff;
   logic [15:0]        c_ang_ff;
   side_type           c_side_ff;

   logic               take;
   logic [15:0]        ang_in;
   logic signed [63:0] p_l, p_d, p_len;

   assign req_ready = adv && (!hold_v_ff || cnt_ff == VTX_MINUS);
   assign take      = req_valid && req_ready;

   always_comb begin
      hold_v_in = hold_v_ff;
      cnt_in    = cnt_ff;
      if (take) begin
         hold_v_in = 1'b1;
         cnt_in    = VTX_ZERO;
      end else if (adv && hold_v_ff) begin
         if (cnt_ff == VTX_MINUS) begin
            hold_v_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 2'd1;
         end
      end
   end

   always_comb begin
      case (cnt_ff)
         VTX_PLUS:  ang_in = h_ff + THIRD_TURN;
         VTX_MINUS: ang_in = h_ff - THIRD_TURN;
         default:   ang_in = h_ff;
      endcase
   end

   assign p_l   = 64'(spacing) * 64'(a_size_ff);
   assign p_d   = 64'(spacing) * INV_SQRT3_Q30;
   assign p_len = 64'(b_l_ff) * INV_SQRT3_Q30;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         cnt_ff    <= VTX_ZERO;
         a_v_ff    <= 1'b0;
         b_v_ff    <= 1'b0;
         c_v_ff    <= 1'b0;
      end else begin
         hold_v_ff <= hold_v_in;
         cnt_ff    <= cnt_in;
         if (adv) begin
            a_v_ff <= hold_v_ff;
            b_v_ff <= a_v_ff;
            c_v_ff <= b_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ox_ff <= req_offset_x;
         oy_ff <= req_offset_y;
         os_ff <= req_offset_scale;
         h_ff  <= base_heading + req_offset_heading;
      end
      if (adv) begin
         a_vtx_ff  <= cnt_ff;
         a_ang_ff  <= ang_in;
         a_size_ff <= sat32(66'(base_scale) + 66'(os_ff));
         a_sx_ff   <= 33'(base_x) + 33'(ox_ff);
         a_sy_ff   <= 33'(base_y) + 33'(oy_ff);

         b_vtx_ff <= a_vtx_ff;
         b_ang_ff <= a_ang_ff;
         b_l_ff   <= sat32(66'(p_l >>> 16));
         b_d_ff   <= sat32(66'(p_d >>> 30));
         b_sx_ff  <= a_sx_ff;
         b_sy_ff  <= a_sy_ff;

         c_ang_ff       <= b_ang_ff;
         c_side_ff.vtx  <= b_vtx_ff;
         c_side_ff.len  <= sat32(66'(p_len >>> 30));
         c_side_ff.dsc  <= b_d_ff;
         c_side_ff.sx   <= b_sx_ff;
         c_side_ff.sy   <= b_sy_ff;
      end
   end

   assign out_valid = c_v_ff;
   assign out_ang   = c_ang_ff;
   assign out_side  = c_side_ff;

endmodule

>>> rtl/tfp_cordic.sv
// Pipelined rotation CORDIC: one stage per step, quadrant fold before and after.
module tfp_cordic #(
   parameter int STEPS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic [15:0]         in_ang,
   input  tfp_pkg::side_type   in_side,
   output logic                out_valid,
   output logic signed [31:0]  out_cos,
   output logic signed [31:0]  out_sin,
   output tfp_pkg::side_type   out_side
);
   import tfp_pkg::*;

   logic               v_ff    [STEPS+1];
   logic               flip_ff [STEPS+1];
   logic signed [33:0] x_ff    [STEPS+1];
   logic signed [33:0] y_ff    [STEPS+1];
   logic signed [32:0] z_ff    [STEPS+1];
   side_type           side_ff [STEPS+1];

   logic               post_v_ff;
   logic signed [31:0] cos_ff, sin_ff;
   side_type           post_side_ff;

   logic [31:0] a_full, a_fold;
   logic        flip_in;

   assign a_full  = {in_ang, 16'd0};
   assign flip_in = (a_full[31:30] == 2'd1) || (a_full[31:30] == 2'd2);
   assign a_fold  = flip_in ? (a_full ^ 32'h80000000) : a_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         flip_ff[0] <= flip_in;
         x_ff[0]    <= INV_GAIN_Q30;
         y_ff[0]    <= '0;
         z_ff[0]    <= 33'($signed(a_fold));
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [33:0] xs, ys;
      logic signed [32:0] at;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      assign at = 33'(ATAN_TABLE[i]);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (adv) begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            flip_ff[i+1] <= flip_ff[i];
            side_ff[i+1] <= side_ff[i];
            if (!z_ff[i][32]) begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - at;
            end else begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + at;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_v_ff <= 1'b0;
      end else if (adv) begin
         post_v_ff <= v_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cos_ff       <= flip_ff[STEPS] ? 32'(-x_ff[STEPS]) : 32'(x_ff[STEPS]);
         sin_ff       <= flip_ff[STEPS] ? 32'(-y_ff[STEPS]) : 32'(y_ff[STEPS]);
         post_side_ff <= side_ff[STEPS];
      end
   end

   assign out_valid = post_v_ff;
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;
   assign out_side  = post_side_ff;

endmodule

>>> rtl/tfp_back.sv
// Product stage and output stage: scaled trig terms, position sums, saturation.
module tfp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic signed [31:0]  in_cos,
   input  logic signed [31:0]  in_sin,
   input  tfp_pkg::side_type   in_side,
   output logic                rsp_valid,
   output logic [1:0]          rsp_vertex,
   output logic signed [31:0]  rsp_pos_x,
   output logic signed [31:0]  rsp_pos_y,
   output logic signed [31:0]  rsp_dx_dheading,
   output logic signed [31:0]  rsp_dx_dscale,
   output logic signed [31:0]  rsp_dy_dheading,
   output logic signed [31:0]  rsp_dy_dscale,
   output logic                rsp_last
);
   import tfp_pkg::*;

   logic               p_v_ff;
   logic [1:0]         p_vtx_ff;
   logic signed [32:0] p_sx_ff, p_sy_ff;
   logic signed [63:0] lc_ff, ls_ff, dc_ff, ds_ff;

   logic               o_v_ff;
   logic [1:0]         o_vtx_ff;
   logic signed [31:0] o_px_ff, o_py_ff, o_dxh_ff, o_dxs_ff, o_dyh_ff, o_dys_ff;

   logic signed [63:0] tc, ts, tns;
   logic signed [63:0] neg_ls;

   assign tc     = lc_ff >>> 30;
   assign ts     = ls_ff >>> 30;
   assign neg_ls = -ls_ff;
   assign tns    = neg_ls >>> 30;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else if (adv) begin
         p_v_ff <= in_valid;
         o_v_ff <= p_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_vtx_ff <= in_side.vtx;
         p_sx_ff  <= in_side.sx;
         p_sy_ff  <= in_side.sy;
         lc_ff    <= 64'(in_side.len) * 64'(in_cos);
         ls_ff    <= 64'(in_side.len) * 64'(in_sin);
         dc_ff    <= 64'(in_side.dsc) * 64'(in_cos);
         ds_ff    <= 64'(in_side.dsc) * 64'(in_sin);

         o_vtx_ff <= p_vtx_ff;
         o_px_ff  <= sat32(66'(p_sx_ff) + 66'(tc));
         o_py_ff  <= sat32(66'(p_sy_ff) + 66'(ts));
         o_dxh_ff <= sat32(66'(tns));
         o_dxs_ff <= sat32(66'(dc_ff >>> 30));
         o_dyh_ff <= sat32(66'(tc));
         o_dys_ff <= sat32(66'(ds_ff >>> 30));
      end
   end

   assign rsp_valid       = o_v_ff;
   assign rsp_vertex      = o_vtx_ff;
   assign rsp_pos_x       = o_px_ff;
   assign rsp_pos_y       = o_py_ff;
   assign rsp_dx_dheading = o_dxh_ff;
   assign rsp_dx_dscale   = o_dxs_ff;
   assign rsp_dy_dheading = o_dyh_ff;
   assign rsp_dy_dscale   = o_dys_ff;
   assign rsp_last        = (o_vtx_ff == VTX_MINUS);

endmodule

>>> rtl/triangle_formation_points_unit.sv
// Top level: triangle formation vertex positions and heading/size derivatives.
// Each accepted item yields three result items, vertex 0 (+0 deg), 1 (+120 deg)
// and 2 (-120 deg), in that order; last marks vertex 2. The datapath is one
// pipeline that takes one vertex per cycle unless stalled, and results stream
// out one per cycle unless stalled. The vertex issue stage sets the item rate:
// req_ready rises while the third vertex of the held item is issued.
// The path is CORDIC_STEPS + 8 register stages (hold, size, side length,
// scaled length, quadrant fold, CORDIC_STEPS rotations, unfold, products,
// sums); the hold register loads on the edge that accepts the item. The whole
// pipeline holds while a result waits unaccepted, and the output register
// keeps it. Values are Q16.16; angles are 16 bit binary angles.
// Configuration writes are taken at any time (csr_ready is always high)
// but must only be done while the unit is empty.
module triangle_formation_points_unit #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_data,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_offset_x,
   input  logic signed [31:0]  req_offset_y,
   input  logic signed [15:0]  req_offset_heading,
   input  logic signed [31:0]  req_offset_scale,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_vertex,
   output logic signed [31:0]  rsp_pos_x,
   output logic signed [31:0]  rsp_pos_y,
   output logic signed [31:0]  rsp_dx_dheading,
   output logic signed [31:0]  rsp_dx_dscale,
   output logic signed [31:0]  rsp_dy_dheading,
   output logic signed [31:0]  rsp_dy_dscale,
   output logic                rsp_last
);
   import tfp_pkg::*;

   // configuration registers
   logic signed [31:0] base_x_ff, base_y_ff, base_scale_ff, spacing_ff;
   logic [15:0]        base_heading_ff;

   // pipeline advance: every stage moves together unless a result is stuck
   logic adv;

   logic               f_valid;
   logic [15:0]        f_ang;
   side_type           f_side;
   logic               k_valid;
   logic signed [31:0] k_cos, k_sin;
   side_type           k_side;

   assign csr_ready = 1'b1;
   assign adv       = !rsp_valid || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff       <= '0;
         base_y_ff       <= '0;
         base_heading_ff <= '0;
         base_scale_ff   <= 32'sd65536;
         spacing_ff      <= 32'sd65536;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_BASE_X:       base_x_ff       <= csr_data;
            REG_BASE_Y:       base_y_ff       <= csr_data;
            REG_BASE_HEADING: base_heading_ff <= csr_data[15:0];
            REG_BASE_SCALE:   base_scale_ff   <= csr_data;
            REG_SPACING:      spacing_ff      <= csr_data;
            default: ;  // unknown index: dropped
         endcase
      end
   end

   tfp_front u_front (
      .clock              (clock),
      .reset              (reset),
      .adv                (adv),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_offset_x       (req_offset_x),
      .req_offset_y       (req_offset_y),
      .req_offset_heading (req_offset_heading),
      .req_offset_scale   (req_offset_scale),
      .base_x             (base_x_ff),
      .base_y             (base_y_ff),
      .base_heading       (base_heading_ff),
      .base_scale         (base_scale_ff),
      .spacing            (spacing_ff),
      .out_valid          (f_valid),
      .out_ang            (f_ang),
      .out_side           (f_side)
   );

   tfp_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_valid),
      .in_ang    (f_ang),
      .in_side   (f_side),
      .out_valid (k_valid),
      .out_cos   (k_cos),
      .out_sin   (k_sin),
      .out_side  (k_side)
   );

   tfp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .in_valid        (k_valid),
      .in_cos          (k_cos),
      .in_sin          (k_sin),
      .in_side         (k_side),
      .rsp_valid       (rsp_valid),
      .rsp_vertex      (rsp_vertex),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_dx_dheading (rsp_dx_dheading),
      .rsp_dx_dscale   (rsp_dx_dscale),
      .rsp_dy_dheading (rsp_dy_dheading),
      .rsp_dy_dscale   (rsp_dy_dscale),
      .rsp_last        (rsp_last)
   );

endmodule

>>> tb/triangle_formation_points_unit_tb.sv
// Testbench for the triangle formation points unit: vertex and derivative checks.
`timescale 1ns / 1ps

module triangle_formation_points_unit_tb;
   import tfp_pkg::*;

   localparam int STEPS = 16;
   localparam int LATENCY = STEPS + 8;
   // no-accept cycles before the run is declared hung
   localparam int HANG_LIMIT = 20000;

   typedef struct {
      logic [1:0]         vertex;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] dx_dheading;
      logic signed [31:0] dx_dscale;
      logic signed [31:0] dy_dheading;
      logic signed [31:0] dy_dscale;
      logic               last;
   } vertex_item_type;

   // Formation model plus queue of expected vertex items.
   class formation_scoreboard;
      int steps;
      logic signed [31:0] cx, cy, nom_scale, side;
      logic [15:0]        heading;
      vertex_item_type    pending[$];
      int                 errors;
      int                 checked;

      function void clear_regs();
         cx = 0; cy = 0; heading = 0; nom_scale = 32'sd65536; side = 32'sd65536;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] data);
         case (idx)
            REG_BASE_X:       cx = data;
            REG_BASE_Y:       cy = data;
            REG_BASE_HEADING: heading = data[15:0];
            REG_BASE_SCALE:   nom_scale = data;
            REG_SPACING:      side = data;
            default: ;
         endcase
      endfunction

      function longint clamp(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // rotator: cos/sin in Q2.30 of a 16 bit angle
      function void rotate(logic [15:0] ang, output longint c, output longint s);
         logic [31:0] a;
         logic        fold;
         longint      x, y, z, nx;
         a = {ang, 16'h0};
         fold = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
         if (fold) a[31] = ~a[31];
         z = longint'($signed(a));
         x = 652032874;
         y = 0;
         for (int i = 0; i < steps && i < ATAN_LEN; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i); y = y + (x >>> i); z -= longint'(ATAN_TABLE[i]);
            end else begin
               nx = x + (y >>> i); y = y - (x >>> i); z += longint'(ATAN_TABLE[i]);
            end
            x = nx;
         end
         c = fold ? -x : x;
         s = fold ? -y : y;
      endfunction

      function void note_request(logic signed [31:0] ox, logic signed [31:0] oy,
                                 logic signed [15:0] oh, logic signed [31:0] os);
         logic [15:0]     h, ang;
         longint          sz, l, len, dsc, c, s, lc, ls;
         vertex_item_type v;
         h = heading + oh;
         sz = clamp(longint'(nom_scale) + longint'(os));
         l = clamp((longint'(side) * sz) >>> 16);
         len = clamp((l * 619925131) >>> 30);
         dsc = clamp((longint'(side) * 619925131) >>> 30);
         for (int k = 0; k < 3; k++) begin
            ang = (k == 0) ? h : (k == 1) ? h + THIRD_TURN : h - THIRD_TURN;
            rotate(ang, c, s);
            lc = (len * c) >>> 30;
            ls = (len * s) >>> 30;
            v.vertex = k[1:0];
            v.pos_x = clamp(longint'(cx) + longint'(ox) + lc);
            v.pos_y = clamp(longint'(cy) + longint'(oy) + ls);
            v.dx_dheading = clamp((-(len * s)) >>> 30);
            v.dx_dscale = clamp((dsc * c) >>> 30);
            v.dy_dheading = clamp(lc);
            v.dy_dscale = clamp((dsc * s) >>> 30);
            v.last = (k == 2);
            pending.push_back(v);
         end
      endfunction

      function void check_result(vertex_item_type got);
         vertex_item_type want;
         checked++;
         if (pending.size() == 0) begin
            $error("unexpected result item, vertex %0d", got.vertex);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.vertex !== want.vertex) begin
            $error("vertex exp %0d got %0d", want.vertex, got.vertex); errors++;
         end
         if (got.pos_x !== want.pos_x) begin
            $error("pos_x exp %0d got %0d", want.pos_x, got.pos_x); errors++;
         end
         if (got.pos_y !== want.pos_y) begin
            $error("pos_y exp %0d got %0d", want.pos_y, got.pos_y); errors++;
         end
         if (got.dx_dheading !== want.dx_dheading) begin
            $error("dx_dheading exp %0d got %0d", want.dx_dheading, got.dx_dheading);
            errors++;
         end
         if (got.dx_dscale !== want.dx_dscale) begin
            $error("dx_dscale exp %0d got %0d", want.dx_dscale, got.dx_dscale); errors++;
         end
         if (got.dy_dheading !== want.dy_dheading) begin
            $error("dy_dheading exp %0d got %0d", want.dy_dheading, got.dy_dheading);
            errors++;
         end
         if (got.dy_dscale !== want.dy_dscale) begin
            $error("dy_dscale exp %0d got %0d", want.dy_dscale, got.dy_dscale); errors++;
         end
         if (got.last !== want.last) begin
            $error("last exp %0d got %0d", want.last, got.last); errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic csr_valid = 0, csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   logic req_valid = 0, req_ready;
   logic signed [31:0] req_offset_x = 0, req_offset_y = 0, req_offset_scale = 0;
   logic signed [15:0] req_offset_heading = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [1:0] rsp_vertex;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_dx_dheading, rsp_dx_dscale;
   logic signed [31:0] rsp_dy_dheading, rsp_dy_dscale;
   logic rsp_last;

   triangle_formation_points_unit #(.CORDIC_STEPS(STEPS)) dut (.*);

   formation_scoreboard sb;
   int  idle_pct = 31;       // idling odds in percent, both sides
   int  sent = 0;
   int  quiet = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // Result side: random stalls, checks on accepted items at the rising edge.
   always @(posedge clock) begin
      vertex_item_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.vertex = rsp_vertex;
         got.pos_x = rsp_pos_x;
         got.pos_y = rsp_pos_y;
         got.dx_dheading = rsp_dx_dheading;
         got.dx_dscale = rsp_dx_dscale;
         got.dy_dheading = rsp_dy_dheading;
         got.dy_dscale = rsp_dy_dscale;
         got.last = rsp_last;
         sb.check_result(got);
      end
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= idle_pct);
   end

   // Watchdog: counts cycles with no handshake on any channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         quiet <= 0;
      else begin
         quiet <= quiet + 1;
         if (quiet == HANG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", HANG_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic write_csr(csr_index_type idx, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // One item; the payload is held until req_ready is seen at a rising edge.
   task automatic send_offsets(logic signed [31:0] ox, logic signed [31:0] oy,
                               logic signed [15:0] oh, logic signed [31:0] os);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_valid <= 0;
      end
      @(negedge clock);
      req_valid <= 1;
      req_offset_x <= ox;
      req_offset_y <= oy;
      req_offset_heading <= oh;
      req_offset_scale <= os;
      do @(posedge clock); while (!req_ready);
      sb.note_request(ox, oy, oh, os);
      sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] pick32();
      case ($urandom_range(5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(131072) - 65536;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         // mostly moderate offsets so the outputs stay unsaturated
         if ($urandom_range(3) != 0)
            send_offsets($urandom_range(2000000) - 1000000,
                         $urandom_range(2000000) - 1000000,
                         $urandom, $urandom_range(262144) - 131072);
         else
            send_offsets(pick32(), pick32(), $urandom, pick32());
      end
      drain();
   endtask

   initial begin
      sb = new();
      sb.steps = STEPS;
      sb.clear_regs();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: reset settings, cardinal and third-turn headings, field extremes.
      send_offsets(0, 0, 0, 0);
      send_offsets(0, 0, 16'sh4000, 0);
      send_offsets(0, 0, -16'sh8000, 0);
      send_offsets(0, 0, 16'sh7FFF, 0);
      send_offsets(0, 0, 16'sd21845, 0);
      send_offsets(0, 0, -16'sd21845, 0);
      send_offsets(0, 0, 16'sh3FFF, 0);
      send_offsets(0, 0, 16'shC000, 0);
      send_offsets(32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sd100, 32'sh7FFFFFFF);
      send_offsets(32'sh80000000, 32'sh80000000, -16'sd100, 32'sh80000000);
      send_offsets(32'sh7FFFFFFF, 32'sh80000000, 16'sd1, -32'sd65536);
      send_offsets(-32'sd1, 32'sd1, -16'sd1, 32'sd1);
      // sender holds off here until every result is back
      drain();

      write_csr(REG_BASE_X, 32'h7FFFFFFF);
      write_csr(REG_BASE_Y, 32'h80000000);
      write_csr(REG_BASE_HEADING, 16'hFFFF);
      write_csr(REG_BASE_SCALE, 32'h7FFFFFFF);
      write_csr(REG_SPACING, 32'h7FFFFFFF);
      send_offsets(32'sh7FFFFFFF, 32'sh80000000, 16'sd1, 32'sh7FFFFFFF);
      send_offsets(32'sh80000000, 32'sh7FFFFFFF, 16'sh7FFF, 32'sh80000000);
      send_offsets(0, 0, 0, 0);
      drain();

      write_csr(REG_BASE_X, 32'h80000000);
      write_csr(REG_BASE_Y, 32'h7FFFFFFF);
      write_csr(REG_BASE_HEADING, 16'h0000);
      write_csr(REG_BASE_SCALE, 32'h80000000);
      write_csr(REG_SPACING, 32'h80000000);
      send_offsets(32'sh80000000, 32'sh7FFFFFFF, -16'sh8000, 32'sh80000000);
      send_offsets(0, 0, 16'sd5461, 32'sh7FFFFFFF);
      drain();

      // Random phases with normal-range settings, a no-idle stretch, then random settings.
      write_csr(REG_BASE_X, $urandom_range(2000000) - 1000000);
      write_csr(REG_BASE_Y, $urandom_range(2000000) - 1000000);
      write_csr(REG_BASE_HEADING, $urandom);
      write_csr(REG_BASE_SCALE, 32'sd131072);
      write_csr(REG_SPACING, 32'sd3 <<< 16);
      random_phase(100);

      idle_pct = 0;
      random_phase(80);
      idle_pct = 31;

      for (int p = 0; p < 3; p++) begin
         write_csr(REG_BASE_X, pick32());
         write_csr(REG_BASE_Y, pick32());
         write_csr(REG_BASE_HEADING, $urandom);
         write_csr(REG_BASE_SCALE, pick32());
         write_csr(REG_SPACING, pick32());
         random_phase(40);
      end

      $display("covered %0d items, %0d vertex results, register extremes and idle-free burst",
               sent, sb.checked);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
